// ===== rtl/sce_pkg.sv =====
`timescale 1ns / 1ps
package sce_pkg;
   localparam int MaxClauses  = 64;
   localparam int MaxLiterals = 512;
   localparam int WordBits    = 32;
   localparam int VecWords    = (MaxLiterals + WordBits - 1) / WordBits;
   localparam int ClauseBits  = 6;
   localparam int SlotBits    = 9;
   localparam int LitBits     = 9;
   localparam int LenBits     = 10;
   localparam int WordIdxBits = 4;
   localparam int InclDepth   = MaxClauses * MaxLiterals;
   localparam int InclAddrBits = ClauseBits + SlotBits;

   typedef enum logic [3:0] {
      MODE_WR_ENTRY  = 4'd0,
      MODE_WR_LENGTH = 4'd1,
      MODE_WR_XI     = 4'd2,
      MODE_WR_ACTIVE = 4'd3,
      MODE_SET_FEAT  = 4'd4,
      MODE_CLR_FEAT  = 4'd5,
      MODE_WR_PACKED = 4'd6,
      MODE_PREDICT   = 4'd7,
      MODE_UPDATE    = 4'd8,
      MODE_PACKED    = 4'd9
   } mode_type;

   localparam logic CsrClauseCount  = 1'b0;
   localparam logic CsrLiteralCount = 1'b1;
endpackage

// ===== rtl/sparse_clause_evaluator.sv =====
`timescale 1ns / 1ps
// channel   ports                                          handshake
// request   req_mode .. req_length                          start & !busy
// response  rsp_clause_number rsp_clause_out rsp_batch_out  rsp_valid, one cycle
//           rsp_last
// csr       csr_we csr_index csr_wdata                      csr_we, no wait
// write items are applied when accepted. an evaluate item walks each clause: it reads
// the length, takes it and fetches the first list entry, takes each included literal
// in turn and then gives the result, bound by the single read port of the list memory.
// after reset the packed and length stores are cleared by a sweep, with busy high.
// results cannot be stalled by the receiver.
module sparse_clause_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [5:0]  req_clause_index,
   input  logic [8:0]  req_slot_index,
   input  logic [8:0]  req_literal_index,
   input  logic [3:0]  req_word_index,
   input  logic [31:0] req_data_word,
   input  logic [9:0]  req_length,
   output logic        rsp_valid,
   output logic [5:0]  rsp_clause_number,
   output logic        rsp_clause_out,
   output logic [31:0] rsp_batch_out,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LEN, ST_FIRST, ST_WALK, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [6:0]  clause_count_ff;
   logic [9:0]  literal_count_ff;
   logic [9:0]  lengths_mem [sce_pkg::MaxClauses];
   logic [9:0]  len_rd_ff;
   logic [31:0] xi_ff [sce_pkg::VecWords];
   logic [31:0] act_ff [sce_pkg::VecWords];
   logic [3:0]  mode_ff;
   logic [5:0]  clause_ff;
   logic [6:0]  nc_ff;
   logic [9:0]  n_ff;
   logic [9:0]  k_ff;
   logic        single_ff;
   logic [31:0] batch_ff;
   logic [8:0]  clr_ff;

   // effective counts
   logic [9:0]  lits_eff;
   logic [8:0]  feats;
   logic [9:0]  feat_hi;
   assign lits_eff = (literal_count_ff > 10'd512) ? 10'd512 : literal_count_ff;
   assign feats    = lits_eff[9:1];
   assign feat_hi  = {1'b0, req_literal_index} + {1'b0, feats};

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // list memory
   logic        incl_we;
   logic [14:0] incl_raddr;
   logic [8:0]  incl_rdata;
   assign incl_we = accept && (req_mode == sce_pkg::MODE_WR_ENTRY);
   assign incl_raddr = {clause_ff, k_ff[8:0]};
   sce_incl_ram u_incl (
      .clock  (clock),
      .wr_en  (incl_we),
      .wr_addr({req_clause_index, req_slot_index}),
      .wr_data(req_literal_index),
      .rd_addr(incl_raddr),
      .rd_data(incl_rdata)
   );

   // packed store, sharing the read with the literal fetched this cycle
   logic        pk_we;
   logic [8:0]  pk_waddr;
   logic [31:0] pk_wdata;
   logic [31:0] pk_rdata;
   assign pk_we    = (state_ff == ST_CLEAR) ||
                     (accept && (req_mode == sce_pkg::MODE_WR_PACKED));
   assign pk_waddr = (state_ff == ST_CLEAR) ? clr_ff : req_literal_index;
   assign pk_wdata = (state_ff == ST_CLEAR) ? 32'd0 : req_data_word;
   sce_packed_ram u_packed (
      .clock  (clock),
      .wr_en  (pk_we),
      .wr_addr(pk_waddr),
      .wr_data(pk_wdata),
      .rd_addr(incl_rdata),
      .rd_data(pk_rdata)
   );

   // length store, cleared by the sweep, read address held over ST_LEN
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         lengths_mem[clr_ff[5:0]] <= 10'd0;
      end else if (accept && (req_mode == sce_pkg::MODE_WR_LENGTH)) begin
         lengths_mem[req_clause_index] <= req_length;
      end
      len_rd_ff <= lengths_mem[clause_ff];
   end

   // literal bit lookups on the fetched index
   logic lit_bit, act_bit;
   assign lit_bit = xi_ff[incl_rdata[8:5]][incl_rdata[4:0]];
   assign act_bit = act_ff[incl_rdata[8:5]][incl_rdata[4:0]];

   // packed term comes from the registered packed read; valid in the cycle after a walk cycle
   logic        pk_pend_ff;

   logic        single_in;
   logic [31:0] batch_in;
   always_comb begin
      single_in = single_ff;
      batch_in  = batch_ff;
      if (pk_pend_ff) begin
         batch_in = batch_ff & pk_rdata;
      end
      if (state_ff == ST_WALK) begin
         if (mode_ff == sce_pkg::MODE_PREDICT && !lit_bit) single_in = 1'b0;
         if (mode_ff == sce_pkg::MODE_UPDATE && !lit_bit && act_bit) single_in = 1'b0;
      end
   end

   logic [9:0] cur_len;
   assign cur_len = (len_rd_ff > 10'd512) ? 10'd512 : len_rd_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == 9'd511) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept && (req_mode == sce_pkg::MODE_PREDICT ||
                           req_mode == sce_pkg::MODE_UPDATE ||
                           req_mode == sce_pkg::MODE_PACKED)) begin
               state_in = (clause_count_ff == 7'd0) ? ST_IDLE : ST_LEN;
            end
         end
         ST_LEN:   state_in = ST_FIRST;
         ST_FIRST: state_in = (cur_len == 10'd0) ? ST_DONE : ST_WALK;
         ST_WALK:  state_in = (k_ff == n_ff) ? ST_DONE : ST_WALK;
         ST_DONE:  state_in = ({1'b0, clause_ff} + 7'd1 == nc_ff) ? ST_IDLE : ST_LEN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer, stores and registered outputs
   always_ff @(posedge clock) begin
      rsp_valid  <= !reset && (state_ff == ST_DONE);
      pk_pend_ff <= !reset && (state_ff == ST_WALK);
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= 9'd0;
         clause_count_ff  <= 7'd64;
         literal_count_ff <= 10'd512;
         for (int i = 0; i < sce_pkg::VecWords; i++) begin
            xi_ff[i]  <= 32'd0;
            act_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               sce_pkg::CsrClauseCount:  clause_count_ff  <= csr_wdata[6:0];
               sce_pkg::CsrLiteralCount: literal_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 9'd1;
            ST_IDLE: begin
               if (accept) begin
                  mode_ff   <= req_mode;
                  clause_ff <= 6'd0;
                  nc_ff     <= (clause_count_ff > 7'd64) ? 7'd64 : clause_count_ff;
                  case (req_mode)
                     sce_pkg::MODE_WR_XI:     xi_ff[req_word_index] <= req_data_word;
                     sce_pkg::MODE_WR_ACTIVE: act_ff[req_word_index] <= req_data_word;
                     sce_pkg::MODE_SET_FEAT, sce_pkg::MODE_CLR_FEAT: begin
                        if (req_literal_index < feats) begin
                           xi_ff[req_literal_index[8:5]][req_literal_index[4:0]] <=
                              (req_mode == sce_pkg::MODE_SET_FEAT);
                           if (!feat_hi[9])
                              xi_ff[feat_hi[8:5]][feat_hi[4:0]] <=
                                 (req_mode == sce_pkg::MODE_CLR_FEAT);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_LEN: k_ff <= 10'd0;
            ST_FIRST: begin
               n_ff      <= cur_len;
               k_ff      <= 10'd1;
               single_ff <= (mode_ff == sce_pkg::MODE_UPDATE) || (cur_len != 10'd0);
               batch_ff  <= (cur_len != 10'd0) ? 32'hFFFF_FFFF : 32'd0;
            end
            ST_WALK: begin
               single_ff <= single_in;
               batch_ff  <= batch_in;
               if (k_ff != n_ff) k_ff <= k_ff + 10'd1;
            end
            ST_DONE: begin
               rsp_clause_number <= clause_ff;
               rsp_clause_out    <= (mode_ff == sce_pkg::MODE_PACKED) ? 1'b0 : single_ff;
               rsp_batch_out     <= (mode_ff == sce_pkg::MODE_PACKED) ? batch_in : 32'd0;
               rsp_last          <= ({1'b0, clause_ff} + 7'd1 == nc_ff);
               clause_ff         <= clause_ff + 6'd1;
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/sce_incl_ram.sv =====
`timescale 1ns / 1ps
// included literal list store, one write and one registered read port
module sce_incl_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [sce_pkg::InclAddrBits-1:0]    wr_addr,
   input  logic [sce_pkg::LitBits-1:0]         wr_data,
   input  logic [sce_pkg::InclAddrBits-1:0]    rd_addr,
   output logic [sce_pkg::LitBits-1:0]         rd_data
);
   logic [sce_pkg::LitBits-1:0] mem [sce_pkg::InclDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/sce_packed_ram.sv =====
`timescale 1ns / 1ps
// packed example store, cleared by a sweep after reset
module sce_packed_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [sce_pkg::LitBits-1:0]   wr_addr,
   input  logic [sce_pkg::WordBits-1:0]  wr_data,
   input  logic [sce_pkg::LitBits-1:0]   rd_addr,
   output logic [sce_pkg::WordBits-1:0]  rd_data
);
   logic [sce_pkg::WordBits-1:0] mem [sce_pkg::MaxLiterals];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== bench/sparse_clause_evaluator_tb.sv =====
`timescale 1ns / 1ps
module sparse_clause_evaluator_tb;

   localparam int CycleLimit = 4000000;

   typedef struct {
      logic [3:0]  mode;
      logic [5:0]  clause_index;
      logic [8:0]  slot_index;
      logic [8:0]  literal_index;
      logic [3:0]  word_index;
      logic [31:0] data_word;
      logic [9:0]  length;
   } clause_cmd_type;

   typedef struct {
      logic [5:0]  clause_number;
      logic        clause_out;
      logic [31:0] batch_out;
      logic        last;
   } clause_result_type;

   // clause bank predictor and queue of clause outputs still to come
   class clause_scoreboard;
      logic [8:0]  incl_lits [sce_pkg::MaxClauses][sce_pkg::MaxLiterals];
      logic [9:0]  incl_lens [sce_pkg::MaxClauses];
      logic [31:0] xi_words [sce_pkg::VecWords];
      logic [31:0] act_words [sce_pkg::VecWords];
      logic [31:0] packed_words [sce_pkg::MaxLiterals];
      logic [6:0]  n_clauses;
      logic [9:0]  n_literals;
      clause_result_type pending_q[$];
      int errors;
      int results_seen;
      int evals_seen;

      function new();
         foreach (incl_lits[c, s]) incl_lits[c][s] = '0;
         foreach (incl_lens[c]) incl_lens[c] = '0;
         foreach (xi_words[w]) begin
            xi_words[w] = '0;
            act_words[w] = '0;
         end
         foreach (packed_words[l]) packed_words[l] = '0;
         n_clauses = 7'd64;
         n_literals = 10'd512;
         errors = 0;
         results_seen = 0;
         evals_seen = 0;
      endfunction

      function void set_config(logic idx, logic [9:0] val);
         if (idx == sce_pkg::CsrClauseCount) n_clauses = val[6:0];
         else n_literals = val;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // apply one accepted item and queue the clause outputs it causes
      function void note_item(clause_cmd_type it);
         int lits, feats, nc, n;
         logic [8:0] l;
         clause_result_type r;
         lits = (n_literals > sce_pkg::MaxLiterals) ? sce_pkg::MaxLiterals : n_literals;
         feats = lits / 2;
         case (it.mode)
            sce_pkg::MODE_WR_ENTRY:
               incl_lits[it.clause_index][it.slot_index] = it.literal_index;
            sce_pkg::MODE_WR_LENGTH: incl_lens[it.clause_index] = it.length;
            sce_pkg::MODE_WR_XI: xi_words[it.word_index] = it.data_word;
            sce_pkg::MODE_WR_ACTIVE: act_words[it.word_index] = it.data_word;
            sce_pkg::MODE_SET_FEAT, sce_pkg::MODE_CLR_FEAT: begin
               if (it.literal_index < feats) begin
                  l = it.literal_index;
                  xi_words[l[8:5]][l[4:0]] = (it.mode == sce_pkg::MODE_SET_FEAT);
                  l = 9'(it.literal_index + feats);
                  xi_words[l[8:5]][l[4:0]] = (it.mode == sce_pkg::MODE_CLR_FEAT);
               end
            end
            sce_pkg::MODE_WR_PACKED: packed_words[it.literal_index] = it.data_word;
            sce_pkg::MODE_PREDICT, sce_pkg::MODE_UPDATE, sce_pkg::MODE_PACKED: begin
               evals_seen++;
               nc = (n_clauses > sce_pkg::MaxClauses) ? sce_pkg::MaxClauses : n_clauses;
               for (int c = 0; c < nc; c++) begin
                  n = (incl_lens[c] > sce_pkg::MaxLiterals) ? sce_pkg::MaxLiterals :
                      incl_lens[c];
                  r.clause_number = 6'(c);
                  r.clause_out = 1'b0;
                  r.batch_out = '0;
                  r.last = (c + 1 == nc);
                  if (it.mode == sce_pkg::MODE_PREDICT) begin
                     r.clause_out = (n != 0);
                     for (int k = 0; k < n; k++) begin
                        l = incl_lits[c][k];
                        if (!xi_words[l[8:5]][l[4:0]]) r.clause_out = 1'b0;
                     end
                  end else if (it.mode == sce_pkg::MODE_UPDATE) begin
                     r.clause_out = 1'b1;
                     for (int k = 0; k < n; k++) begin
                        l = incl_lits[c][k];
                        if (!xi_words[l[8:5]][l[4:0]] && act_words[l[8:5]][l[4:0]])
                           r.clause_out = 1'b0;
                     end
                  end else begin
                     r.batch_out = (n != 0) ? 32'hFFFF_FFFF : 32'h0;
                     for (int k = 0; k < n; k++)
                        r.batch_out &= packed_words[incl_lits[c][k]];
                  end
                  pending_q.push_back(r);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(clause_result_type got);
         clause_result_type e;
         results_seen++;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected clause output clause %0d out %0b batch %h last %0b",
                     $time, got.clause_number, got.clause_out, got.batch_out, got.last);
            return;
         end
         e = pending_q.pop_front();
         if (got.clause_number !== e.clause_number) begin
            errors++;
            $display("%0t: clause_number expected %0d actual %0d",
                     $time, e.clause_number, got.clause_number);
         end
         if (got.clause_out !== e.clause_out) begin
            errors++;
            $display("%0t: clause_out of clause %0d expected %0b actual %0b",
                     $time, e.clause_number, e.clause_out, got.clause_out);
         end
         if (got.batch_out !== e.batch_out) begin
            errors++;
            $display("%0t: batch_out of clause %0d expected %h actual %h",
                     $time, e.clause_number, e.batch_out, got.batch_out);
         end
         if (got.last !== e.last) begin
            errors++;
            $display("%0t: last of clause %0d expected %0b actual %0b",
                     $time, e.clause_number, e.last, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_mode;
   logic [5:0]  req_clause_index;
   logic [8:0]  req_slot_index;
   logic [8:0]  req_literal_index;
   logic [3:0]  req_word_index;
   logic [31:0] req_data_word;
   logic [9:0]  req_length;
   logic        rsp_valid;
   logic [5:0]  rsp_clause_number;
   logic        rsp_clause_out;
   logic [31:0] rsp_batch_out;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [9:0]  csr_wdata;

   clause_scoreboard sb;
   int cycles;
   int items_sent;
   // slots already written per clause, so no list ever reaches an unwritten entry
   bit slot_written [sce_pkg::MaxClauses][sce_pkg::MaxLiterals];

   sparse_clause_evaluator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_clause_index(req_clause_index),
      .req_slot_index(req_slot_index), .req_literal_index(req_literal_index),
      .req_word_index(req_word_index), .req_data_word(req_data_word),
      .req_length(req_length), .rsp_valid(rsp_valid),
      .rsp_clause_number(rsp_clause_number), .rsp_clause_out(rsp_clause_out),
      .rsp_batch_out(rsp_batch_out), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result monitor, sampled mid-cycle
   always @(negedge clock) begin
      clause_result_type got;
      if (!reset && rsp_valid) begin
         got.clause_number = rsp_clause_number;
         got.clause_out = rsp_clause_out;
         got.batch_out = rsp_batch_out;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   function automatic int written_prefix(int c);
      int p;
      p = 0;
      while (p < sce_pkg::MaxLiterals && slot_written[c][p]) p++;
      return p;
   endfunction

   function automatic clause_cmd_type junk_cmd();
      clause_cmd_type it;
      it.mode = sce_pkg::MODE_WR_ENTRY;
      it.clause_index = 6'($urandom);
      it.slot_index = 9'($urandom);
      it.literal_index = 9'($urandom);
      it.word_index = 4'($urandom);
      it.data_word = $urandom;
      it.length = 10'($urandom);
      return it;
   endfunction

   function automatic clause_cmd_type entry_cmd(int c, int s, int l);
      clause_cmd_type it;
      it = junk_cmd();
      it.mode = sce_pkg::MODE_WR_ENTRY;
      it.clause_index = 6'(c);
      it.slot_index = 9'(s);
      it.literal_index = 9'(l);
      slot_written[c][s] = 1'b1;
      return it;
   endfunction

   function automatic clause_cmd_type make_cmd(logic [3:0] m, int a, int b);
      clause_cmd_type it;
      it = junk_cmd();
      it.mode = m;
      case (m)
         sce_pkg::MODE_WR_LENGTH: begin
            it.clause_index = 6'(a);
            it.length = 10'(b);
         end
         sce_pkg::MODE_WR_XI, sce_pkg::MODE_WR_ACTIVE: begin
            it.word_index = 4'(a);
            it.data_word = b;
         end
         sce_pkg::MODE_SET_FEAT, sce_pkg::MODE_CLR_FEAT: it.literal_index = 9'(a);
         sce_pkg::MODE_WR_PACKED: begin
            it.literal_index = 9'(a);
            it.data_word = b;
         end
         default: ;
      endcase
      return it;
   endfunction

   // random item, weighted toward building lists and evaluating them
   function automatic clause_cmd_type random_cmd();
      clause_cmd_type it;
      int pick, c, p, n;
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, sce_pkg::MaxClauses - 1);
      p = written_prefix(c);
      if (pick < 28) begin
         if (p < sce_pkg::MaxLiterals && $urandom_range(0, 9) != 0)
            it = entry_cmd(c, p, $urandom_range(0, sce_pkg::MaxLiterals - 1));
         else
            it = entry_cmd(c, $urandom_range(0, sce_pkg::MaxLiterals - 1),
                           $urandom_range(0, sce_pkg::MaxLiterals - 1));
      end else if (pick < 42) begin
         n = (p > 10) ? 10 : p;
         n = $urandom_range(0, n);
         if (p == sce_pkg::MaxLiterals && $urandom_range(0, 7) == 0)
            n = $urandom_range(512, 1023);
         it = make_cmd(sce_pkg::MODE_WR_LENGTH, c, n);
      end else if (pick < 50) begin
         it = make_cmd(sce_pkg::MODE_WR_XI, $urandom_range(0, 15), $urandom);
      end else if (pick < 56) begin
         it = make_cmd(sce_pkg::MODE_WR_ACTIVE, $urandom_range(0, 15), $urandom);
      end else if (pick < 66) begin
         it = make_cmd($urandom_range(0, 1) ? sce_pkg::MODE_SET_FEAT : sce_pkg::MODE_CLR_FEAT,
                       $urandom_range(0, 511), 0);
      end else if (pick < 73) begin
         it = make_cmd(sce_pkg::MODE_WR_PACKED, $urandom_range(0, 511), $urandom | $urandom);
      end else if (pick < 97) begin
         it = make_cmd(4'($urandom_range(sce_pkg::MODE_PREDICT, sce_pkg::MODE_PACKED)), 0, 0);
      end else begin
         it = make_cmd(4'($urandom_range(10, 15)), 0, 0);
      end
      return it;
   endfunction

   // present one item from a rising edge, return at the edge that takes it
   task automatic send_cmd(clause_cmd_type it);
      start <= 1'b1;
      req_mode <= it.mode;
      req_clause_index <= it.clause_index;
      req_slot_index <= it.slot_index;
      req_literal_index <= it.literal_index;
      req_word_index <= it.word_index;
      req_data_word <= it.data_word;
      req_length <= it.length;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      sb.note_item(it);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (sb.pending() == 0 && !busy) break;
      end
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [9:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_config(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int cc_pick, lc_pick;
      clause_cmd_type it;
      sb = new();
      foreach (slot_written[c, s]) slot_written[c][s] = 1'b0;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = '0;
      req_clause_index = '0;
      req_slot_index = '0;
      req_literal_index = '0;
      req_word_index = '0;
      req_data_word = '0;
      req_length = '0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      cycles = 0;
      items_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: small bank, every mode, empty clause, ignored items
      csr_write(sce_pkg::CsrClauseCount, 10'd4);
      csr_write(sce_pkg::CsrLiteralCount, 10'd16);
      send_cmd(entry_cmd(0, 0, 3));
      send_cmd(entry_cmd(0, 1, 10));
      send_cmd(entry_cmd(1, 0, 511));
      send_cmd(make_cmd(sce_pkg::MODE_WR_LENGTH, 0, 2));
      send_cmd(make_cmd(sce_pkg::MODE_WR_LENGTH, 1, 1));
      send_cmd(make_cmd(sce_pkg::MODE_WR_LENGTH, 2, 0));
      send_cmd(make_cmd(sce_pkg::MODE_WR_XI, 0, 32'hFFFF_FFFF));
      send_cmd(make_cmd(sce_pkg::MODE_WR_ACTIVE, 15, 32'h8000_0000));
      send_cmd(make_cmd(sce_pkg::MODE_PREDICT, 0, 0));
      send_cmd(make_cmd(sce_pkg::MODE_CLR_FEAT, 3, 0));
      send_cmd(make_cmd(sce_pkg::MODE_SET_FEAT, 2, 0));
      send_cmd(make_cmd(sce_pkg::MODE_SET_FEAT, 8, 0));
      send_cmd(make_cmd(sce_pkg::MODE_CLR_FEAT, 511, 0));
      send_cmd(make_cmd(sce_pkg::MODE_UPDATE, 0, 0));
      send_cmd(make_cmd(sce_pkg::MODE_WR_PACKED, 3, 32'hF0F0_FFFF));
      send_cmd(make_cmd(sce_pkg::MODE_WR_PACKED, 10, 32'h0FF0_FFFF));
      send_cmd(make_cmd(sce_pkg::MODE_WR_PACKED, 511, 32'h0000_0000));
      send_cmd(make_cmd(sce_pkg::MODE_PACKED, 0, 0));
      send_cmd(make_cmd(4'd10, 0, 0));
      send_cmd(make_cmd(4'd15, 0, 0));
      send_cmd(make_cmd(sce_pkg::MODE_WR_XI, 15, 32'h0));
      send_cmd(make_cmd(sce_pkg::MODE_UPDATE, 0, 0));

      // full clause count, clamped literal count, then no clauses at all
      csr_write(sce_pkg::CsrClauseCount, 10'd64);
      csr_write(sce_pkg::CsrLiteralCount, 10'd1023);
      send_cmd(make_cmd(sce_pkg::MODE_PACKED, 0, 0));
      send_cmd(make_cmd(sce_pkg::MODE_UPDATE, 0, 0));
      csr_write(sce_pkg::CsrClauseCount, 10'd0);
      send_cmd(make_cmd(sce_pkg::MODE_PREDICT, 0, 0));

      // random phases with a fresh setting each
      for (int ph = 0; ph < 10; ph++) begin
         cc_pick = $urandom_range(0, 5);
         lc_pick = $urandom_range(0, 4);
         csr_write(sce_pkg::CsrClauseCount, (cc_pick == 0) ? 10'd1 :
                   (cc_pick == 1) ? 10'd64 :
                   (cc_pick == 2) ? 10'd127 : (cc_pick == 3) ? 10'd0 :
                   10'($urandom_range(1, 64)));
         csr_write(sce_pkg::CsrLiteralCount, (lc_pick == 0) ? 10'd2 :
                   (lc_pick == 1) ? 10'd512 :
                   (lc_pick == 2) ? 10'(1024 - 1) : 10'($urandom_range(2, 512)));
         for (int i = 0; i < 26; i++) begin
            if (ph == 4 && i == 14) wait_drained();
            it = random_cmd();
            idle_gap();
            send_cmd(it);
         end
      end

      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (sb.pending() == 0) break;
      end
      repeat (200) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d clause outputs never arrived", $time, sb.pending());
      end
      $display("sent %0d items including %0d evaluations over 10 random settings",
               items_sent, sb.evals_seen);
      $display("checked %0d clause outputs, %0d mismatches", sb.results_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/sce_pkg.sv
rtl/sce_incl_ram.sv
rtl/sce_packed_ram.sv
rtl/sparse_clause_evaluator.sv
bench/sparse_clause_evaluator_tb.sv
